// File: rtl/ffpm_pkg.sv
// Shared types and constants for the FIFO-fed PCM mixer.
package ffpm_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int FIFO_DEPTH_DEF   = 1024;
    localparam int SAMPLE_W         = 16;
    localparam int CHANNEL_W        = 2;
    localparam int ACTIVE_W         = 3;
    localparam int MIX_DIVISOR      = 32767;
    localparam int DIV_SHIFT        = 15;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic [CHANNEL_W-1:0]       channel;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       frame_end;
    } ffpm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic [ACTIVE_W-1:0]        active_channels;
        logic                       frame_last;
    } ffpm_out_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic fold_en;
    } fold_ctrl_t;

endpackage

// File: rtl/fifo_fed_pcm_mixer.sv
// Put: a new transaction every cycle while no pull is in progress. Pull: once accepted, the input
// stays blocked until the result is registered and the state machine returns to idle.
// Each channel takes a memory read, a multiply and a fold step through the accumulator.
// A pull waits in its final state only while the previous result is not yet taken.
// Reset (aresetn low, synchronous) empties every FIFO; sample memory contents are not cleared.
module fifo_fed_pcm_mixer #(
    parameter int NUM_CHANNELS = ffpm_pkg::NUM_CHANNELS_DEF,
    parameter int FIFO_DEPTH   = ffpm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffpm_pkg::ffpm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffpm_pkg::ffpm_out_t m_data
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ADDR_W   = $clog2(FIFO_DEPTH);
    localparam int PTR_W    = $clog2(2 * FIFO_DEPTH);
    localparam int RAM_AW   = CH_IDX_W + ADDR_W;
    localparam int RAM_D    = NUM_CHANNELS * (2 ** ADDR_W);
    localparam int SW       = ffpm_pkg::SAMPLE_W;
    localparam int AW       = ffpm_pkg::ACTIVE_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_FOLD = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(2 * FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_addr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p >= PTR_W'(FIFO_DEPTH)) begin
            r = p - PTR_W'(FIFO_DEPTH);
        end else begin
            r = p;
        end
        return r[ADDR_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     wp_reg [NUM_CHANNELS];
    logic [PTR_W-1:0]     rp_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] full, empty;
    logic [CH_IDX_W-1:0]  cnt_reg;
    logic [AW-1:0]        active_reg;
    logic                 avail_reg;
    logic                 frame_reg;
    logic                 out_valid_reg;
    ffpm_pkg::ffpm_out_t  out_data_reg;

    logic                 s_fire;
    logic                 put_ok;
    logic [CH_IDX_W-1:0]  put_ch;
    logic                 rd_en;
    logic signed [SW-1:0] rd_data;
    logic signed [SW-1:0] b_val;
    logic signed [SW-1:0] acc;
    ffpm_pkg::fold_ctrl_t fold_ctrl;
    logic                 last_ch;

    // Fill level per channel, one lane each.
    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lvl
        logic [PTR_W:0] fill;
        always_comb begin
            if (wp_reg[i] >= rp_reg[i]) begin
                fill = (PTR_W+1)'(wp_reg[i]) - (PTR_W+1)'(rp_reg[i]);
            end else begin
                fill = (PTR_W+1)'(wp_reg[i]) + (PTR_W+1)'(2 * FIFO_DEPTH)
                     - (PTR_W+1)'(rp_reg[i]);
            end
            full[i]  = (fill == (PTR_W+1)'(FIFO_DEPTH));
            empty[i] = (wp_reg[i] == rp_reg[i]);
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign put_ch  = CH_IDX_W'(s_data.channel);
    assign put_ok  = s_fire && (s_data.req_type == ffpm_pkg::REQ_PUT)
                     && (32'(s_data.channel) < NUM_CHANNELS) && !full[put_ch];
    assign rd_en   = (state_reg == S_READ);
    assign last_ch = (cnt_reg == CH_IDX_W'(NUM_CHANNELS - 1));
    assign b_val   = avail_reg ? rd_data : '0;

    always_comb begin
        fold_ctrl.clear   = s_fire && (s_data.req_type == ffpm_pkg::REQ_PULL);
        fold_ctrl.mul_en  = (state_reg == S_MUL);
        fold_ctrl.fold_en = (state_reg == S_FOLD);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_data.req_type == ffpm_pkg::REQ_PULL)) begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_FOLD;
            S_FOLD: state_next = last_ch ? S_DONE : S_READ;
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            active_reg    <= '0;
            avail_reg     <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (put_ok) begin
                wp_reg[put_ch] <= ptr_inc(wp_reg[put_ch]);
            end
            if (fold_ctrl.clear) begin
                cnt_reg    <= '0;
                active_reg <= '0;
            end
            if (state_reg == S_READ) begin
                avail_reg <= !empty[cnt_reg];
                if (!empty[cnt_reg]) begin
                    rp_reg[cnt_reg] <= ptr_inc(rp_reg[cnt_reg]);
                    if (active_reg != {AW{1'b1}}) begin
                        active_reg <= active_reg + AW'(1);
                    end
                end
            end
            if ((state_reg == S_FOLD) && !last_ch) begin
                cnt_reg <= cnt_reg + CH_IDX_W'(1);
            end
            if ((state_reg == S_DONE) && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fold_ctrl.clear) begin
            frame_reg <= s_data.frame_end;
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || m_ready)) begin
            out_data_reg.mixed_sample    <= acc;
            out_data_reg.active_channels <= active_reg;
            out_data_reg.frame_last      <= frame_reg;
        end
    end

    ffpm_sample_ram #(
        .ADDR_W (RAM_AW),
        .DEPTH  (RAM_D)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (put_ok),
        .wr_addr ({put_ch, ptr_addr(wp_reg[put_ch])}),
        .wr_data (s_data.sample_in),
        .rd_en   (rd_en),
        .rd_addr ({cnt_reg, ptr_addr(rp_reg[cnt_reg])}),
        .rd_data (rd_data)
    );

    ffpm_fold_unit u_fold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fold_ctrl),
        .b_in    (b_val),
        .acc     (acc)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_pull_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_data.req_type == ffpm_pkg::REQ_PULL)) |=> !s_ready)
        else $error("input accepted while a pull is in progress");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final pull state");

    a_active_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (NUM_CHANNELS <= 7)) |-> (32'(m_data.active_channels) <= NUM_CHANNELS))
        else $error("active channel count exceeds the channel count");

endmodule

// File: rtl/ffpm_sample_ram.sv
// Sample store shared by all channel FIFOs: one write port, one registered read port.
module ffpm_sample_ram #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic signed [ffpm_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                                rd_en,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic signed [ffpm_pkg::SAMPLE_W-1:0] rd_data
);

    logic signed [ffpm_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic signed [ffpm_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ffpm_fold_unit.sv
// Mixing accumulator: registered product, then the fold step with saturation.
module ffpm_fold_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ffpm_pkg::fold_ctrl_t                 ctrl,
    input  logic signed [ffpm_pkg::SAMPLE_W-1:0]  b_in,
    output logic signed [ffpm_pkg::SAMPLE_W-1:0]  acc
);

    localparam int SW = ffpm_pkg::SAMPLE_W;
    localparam int PW = 2 * SW;
    localparam int DS = ffpm_pkg::DIV_SHIFT;

    logic signed [SW-1:0] acc_reg, acc_next;
    logic signed [SW-1:0] b_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 pos_reg, neg_reg;

    // Shared-sign products are positive and at most 2**30.
    logic [PW-2:0]        p_mag;
    logic [PW-2-DS:0]     q_est;
    logic [DS:0]          rem_low;
    logic [PW-1-DS:0]     rem_sum;
    logic [PW-1-DS:0]     quot;
    logic signed [SW+2:0] sum;
    logic signed [SW+2:0] res;

    always_comb begin
        p_mag   = prod_reg[PW-2:0];
        q_est   = p_mag[PW-2:DS];
        rem_low = {1'b0, p_mag[DS-1:0]};
        // p - q_est*(2**15-1) equals the low bits plus q_est; one correction suffices.
        rem_sum = (PW-DS)'(rem_low) + (PW-DS)'(q_est);
        quot    = (PW-DS)'(q_est) +
                  ((rem_sum >= (PW-DS)'(ffpm_pkg::MIX_DIVISOR)) ? (PW-DS)'(1) : (PW-DS)'(0));
        sum     = (SW+3)'(acc_reg) + (SW+3)'(b_reg);
        if (pos_reg) begin
            res = sum - $signed({1'b0, quot[SW:0]});
        end else if (neg_reg) begin
            res = sum + $signed({1'b0, quot[SW:0]});
        end else begin
            res = sum;
        end
        if (res > (SW+3)'(32767)) begin
            acc_next = SW'(32767);
        end else if (res < -(SW+3)'(32768)) begin
            acc_next = -SW'(32768);
        end else begin
            acc_next = res[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.fold_en) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= acc_reg * b_in;
            b_reg    <= b_in;
            pos_reg  <= (acc_reg > 0) && (b_in > 0);
            neg_reg  <= (acc_reg < 0) && (b_in < 0);
        end
    end

    assign acc = acc_reg;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the FIFO-fed PCM mixer, with its own mixing predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = ffpm_pkg::NUM_CHANNELS_DEF;
    localparam int DEPTH       = ffpm_pkg::FIFO_DEPTH_DEF;
    localparam int SW          = ffpm_pkg::SAMPLE_W;
    localparam int CW          = ffpm_pkg::CHANNEL_W;
    localparam int AW          = ffpm_pkg::ACTIVE_W;
    localparam int PULL_CYCLES = 3 * NUM_CH + 2;
    localparam int CYCLE_LIMIT = 1000000;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ffpm_pkg::ffpm_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ffpm_pkg::ffpm_out_t m_data;

    // Predictor state: one sample queue per channel plus the results still owed.
    logic signed [SW-1:0] chan_samples [NUM_CH][$];
    ffpm_pkg::ffpm_out_t  pending_mixes[$];

    int errors         = 0;
    int cycle_count    = 0;
    int sent_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    fifo_fed_pcm_mixer #(
        .NUM_CHANNELS(NUM_CH),
        .FIFO_DEPTH  (DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: a long hold-off takes priority over the random stall rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int mix_pair(int a, int b);
        int r;
        if (a > 0 && b > 0) begin
            r = a + b - (a * b) / ffpm_pkg::MIX_DIVISOR;
        end else if (a < 0 && b < 0) begin
            r = a + b + (a * b) / ffpm_pkg::MIX_DIVISOR;
        end else begin
            r = a + b;
        end
        if (r > 32767) r = 32767;
        else if (r < -32768) r = -32768;
        return r;
    endfunction

    // Updates the channel queues for one accepted transaction and queues the mix it owes.
    function automatic void track_request(ffpm_pkg::ffpm_in_t req);
        int                  acc;
        int                  b;
        int                  active;
        ffpm_pkg::ffpm_out_t mix;
        if (req.req_type == ffpm_pkg::REQ_PUT) begin
            if (req.channel < NUM_CH && chan_samples[req.channel].size() < DEPTH)
                chan_samples[req.channel].push_back(req.sample_in);
            return;
        end
        acc    = 0;
        active = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            b = 0;
            if (chan_samples[c].size() != 0) begin
                b = chan_samples[c].pop_front();
                active++;
            end
            acc = mix_pair(acc, b);
        end
        if (active > 7) active = 7;
        mix.mixed_sample    = acc[SW-1:0];
        mix.active_channels = active[AW-1:0];
        mix.frame_last      = req.frame_end;
        pending_mixes.push_back(mix);
    endfunction

    always @(posedge aclk) begin : result_check
        ffpm_pkg::ffpm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_mixes.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual %p", $time, m_data);
            end else begin
                want = pending_mixes.pop_front();
                if (m_data.mixed_sample !== want.mixed_sample) begin
                    errors++;
                    $display("%0t: mixed_sample expected %0d actual %0d", $time,
                             want.mixed_sample, m_data.mixed_sample);
                end
                if (m_data.active_channels !== want.active_channels) begin
                    errors++;
                    $display("%0t: active_channels expected %0d actual %0d", $time,
                             want.active_channels, m_data.active_channels);
                end
                if (m_data.frame_last !== want.frame_last) begin
                    errors++;
                    $display("%0t: frame_last expected %0b actual %0b", $time,
                             want.frame_last, m_data.frame_last);
                end
            end
        end
    end

    function automatic ffpm_pkg::ffpm_in_t make_req(logic kind, logic [CW-1:0] ch,
                                                    logic signed [SW-1:0] smp, logic fend);
        ffpm_pkg::ffpm_in_t r;
        r.req_type  = kind;
        r.channel   = ch;
        r.sample_in = smp;
        r.frame_end = fend;
        return r;
    endfunction

    // Mostly the corner values that steer the fold, with full-range random samples otherwise.
    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            4:       return 16'shffff;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic ffpm_pkg::ffpm_in_t random_pull();
        return make_req(ffpm_pkg::REQ_PULL, CW'($urandom), SW'($urandom), 1'($urandom));
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_req(ffpm_pkg::ffpm_in_t req);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        track_request(req);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_mixes.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Pull with every FIFO empty; channel and sample fields must be ignored.
        send_req(make_req(ffpm_pkg::REQ_PULL, 2'd3, 16'sh8000, 1'b1));
        // Two positive full-scale samples meet in the positive fold.
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd0, 16'sh7fff, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd1, 16'sh7fff, 1'b1));
        send_req(make_req(ffpm_pkg::REQ_PULL, 2'd1, 16'sh7fff, 1'b0));
        // Negative extremes, then a sign change at the last channel.
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd0, 16'sh8000, 1'b1));
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd1, 16'sh8000, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd2, 16'shffff, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd3, 16'sh0001, 1'b1));
        send_req(make_req(ffpm_pkg::REQ_PULL, 2'd0, 16'sh0000, 1'b1));
        // Mixed signs with empty channels in between.
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd0, 16'sd1000, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd2, -16'sd2000, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PULL, 2'd2, 16'sh5555, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd1, 16'sh0000, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PUT, 2'd3, 16'shffff, 1'b0));
        send_req(make_req(ffpm_pkg::REQ_PULL, 2'd3, 16'shaaaa, 1'b1));
        wait_drained();
    endtask

    // Fills one channel past its depth so the extra puts are dropped, then pulls a few.
    task automatic test_full_fifo();
        logic [CW-1:0] ch;
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        ch = CW'($urandom_range(NUM_CH - 1));
        repeat (DEPTH + 4)
            send_req(make_req(ffpm_pkg::REQ_PUT, ch, SW'($urandom), 1'($urandom)));
        repeat (6) send_req(random_pull());
        wait_drained();
    endtask

    // The receiver holds off while pulls keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        repeat (6) begin
            for (int c = 0; c < NUM_CH; c++)
                send_req(make_req(ffpm_pkg::REQ_PUT, CW'(c), pick_sample(), 1'($urandom)));
            send_req(random_pull());
            send_req(random_pull());
        end
        // The sender now pauses until every owed mix has come out.
        wait_drained();
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct, int items);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = sent_count + items;
        while (sent_count < target) begin
            if ($urandom_range(99) < 70) begin
                // A frame: samples for most channels, then one or two pulls.
                for (int c = 0; c < NUM_CH; c++)
                    if ($urandom_range(99) < 80)
                        send_req(make_req(ffpm_pkg::REQ_PUT, CW'(c), pick_sample(),
                                          1'($urandom)));
                repeat ($urandom_range(1, 2)) send_req(random_pull());
            end else if ($urandom_range(1)) begin
                send_req(make_req(ffpm_pkg::REQ_PUT, CW'($urandom), SW'($urandom),
                                  1'($urandom)));
            end else begin
                send_req(random_pull());
            end
        end
    endtask

    task automatic test_random();
        run_random_phase(0, 0, 35);
        run_random_phase(61, 0, 35);
        run_random_phase(0, 61, 35);
        run_random_phase(33, 33, 35);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_fifo();
        test_backpressure();
        test_random();
        repeat (PULL_CYCLES + 8) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ffpm_pkg.sv
rtl/ffpm_sample_ram.sv
rtl/ffpm_fold_unit.sv
rtl/fifo_fed_pcm_mixer.sv
bench/tb_top.sv
